// ===== sv/swtq_pkg.sv =====
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared widths, codes and controller/datapath types for the sleep wake-up
// timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package swtq_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int PID_W   = 16;
  localparam int MSECS_W = 32;
  localparam int TIME_W  = 64;
  localparam int MSPT_W  = 10;
  localparam int TSL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 1;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [CFGI_W-1:0] REG_MS_PER_TICK  = 1'b0;
  localparam logic [CFGI_W-1:0] REG_TIMESLICE_MS = 1'b1;

  localparam logic [MSPT_W-1:0] MS_PER_TICK_RST  = 10'd10;
  localparam logic [TSL_W-1:0]  TIMESLICE_RST    = 16'd50;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_WOKEN  = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic sleep;
    logic add;
    logic keep;
    logic wake;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_end;
    logic due;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/swtq_in_if.sv =====
// ----------------------------------------------------------------------------
// swtq_in_if
// Request channel: sleep requests and timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface swtq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [swtq_pkg::PID_W-1:0]    pid;
  logic [swtq_pkg::MSECS_W-1:0]  msecs;

  modport source (output valid, output func, output pid, output msecs, input ready);
  modport sink   (input valid, input func, input pid, input msecs, output ready);
endinterface

`default_nettype wire

// ===== sv/swtq_out_if.sv =====
// ----------------------------------------------------------------------------
// swtq_out_if
// Result channel: accepted, rejected, woken and tick-done results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swtq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [swtq_pkg::PID_W-1:0]  proc_id;
  logic                        reschedule;
  logic                        last;

  modport source (output valid, output kind, output proc_id, output reschedule,
                  output last, input ready);
  modport sink   (input valid, input kind, input proc_id, input reschedule,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/swtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swtq_ctrl
// Controller: sequences request capture, sleep insertion and the tick scan.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swtq_pkg::status_t status,
  output swtq_pkg::cmd_t         cmd
);

  swtq_pkg::state_t state;
  swtq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      swtq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = swtq_pkg::S_EXEC;
        end
      end
      swtq_pkg::S_EXEC: begin
        if (status.is_tick) begin
          cmd.add    = 1'b1;
          state_next = swtq_pkg::S_SCAN;
        end else if (status.out_free) begin
          cmd.sleep  = 1'b1;
          state_next = swtq_pkg::S_IDLE;
        end
      end
      swtq_pkg::S_SCAN: begin
        if (status.scan_end) begin
          state_next = swtq_pkg::S_DONE;
        end else if (!status.due) begin
          cmd.keep = 1'b1;
        end else if (status.out_free) begin
          cmd.wake = 1'b1;
        end
      end
      swtq_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = swtq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swtq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/swtq_dp.sv =====
// ----------------------------------------------------------------------------
// swtq_dp
// Datapath: clock, reschedule mark, sleep table with in-place compaction,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swtq_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [swtq_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_func,
  input  wire logic [swtq_pkg::PID_W-1:0]    in_pid,
  input  wire logic [swtq_pkg::MSECS_W-1:0]  in_msecs,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [swtq_pkg::PID_W-1:0]         out_proc_id,
  output logic                               out_reschedule,
  output logic                               out_last,
  input  wire swtq_pkg::cmd_t                cmd,
  output swtq_pkg::status_t                  status
);

  logic                          func_q;
  logic [swtq_pkg::PID_W-1:0]    pid_q;
  logic [swtq_pkg::MSECS_W-1:0]  msecs_q;

  logic [swtq_pkg::MSPT_W-1:0]   ms_per_tick;
  logic [swtq_pkg::TSL_W-1:0]    timeslice_ms;

  logic [swtq_pkg::TIME_W-1:0]   elapsed_ms;
  logic [swtq_pkg::TIME_W-1:0]   last_resched_ms;
  logic [swtq_pkg::CNT_W-1:0]    count;
  logic [swtq_pkg::CNT_W-1:0]    scan_i;
  logic [swtq_pkg::CNT_W-1:0]    keep_i;
  logic                          woke;

  logic [swtq_pkg::PID_W-1:0]    ent_pid  [swtq_pkg::ENTRIES];
  logic [swtq_pkg::TIME_W-1:0]   ent_wake [swtq_pkg::ENTRIES];

  logic [swtq_pkg::PID_W-1:0]    rd_pid;
  logic [swtq_pkg::TIME_W-1:0]   rd_wake;
  logic                          full;
  logic                          out_free;
  logic [swtq_pkg::TIME_W-1:0]   since_resched;
  logic                          resched_now;

  assign rd_pid        = ent_pid[scan_i[swtq_pkg::IDX_W-1:0]];
  assign rd_wake       = ent_wake[scan_i[swtq_pkg::IDX_W-1:0]];
  assign full          = (count == swtq_pkg::CNT_W'(swtq_pkg::ENTRIES));
  assign out_free      = !out_valid || out_ready;
  assign since_resched = elapsed_ms - last_resched_ms;
  assign resched_now   = woke ||
                         (since_resched >= {{(swtq_pkg::TIME_W-swtq_pkg::TSL_W){1'b0}},
                                            timeslice_ms});

  assign status.is_tick  = (func_q == swtq_pkg::FUNC_TICK);
  assign status.scan_end = (scan_i == count);
  assign status.due      = (rd_wake <= elapsed_ms);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_per_tick  <= swtq_pkg::MS_PER_TICK_RST;
      timeslice_ms <= swtq_pkg::TIMESLICE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swtq_pkg::REG_MS_PER_TICK:  ms_per_tick  <= cfg_data[swtq_pkg::MSPT_W-1:0];
        swtq_pkg::REG_TIMESLICE_MS: timeslice_ms <= cfg_data[swtq_pkg::TSL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= in_func;
      pid_q   <= in_pid;
      msecs_q <= in_msecs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms      <= '0;
      last_resched_ms <= '0;
      count           <= '0;
      scan_i          <= '0;
      keep_i          <= '0;
      woke            <= 1'b0;
    end else begin
      if (cmd.sleep && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.add) begin
        elapsed_ms <= elapsed_ms +
                      {{(swtq_pkg::TIME_W-swtq_pkg::MSPT_W){1'b0}}, ms_per_tick};
        scan_i     <= '0;
        keep_i     <= '0;
        woke       <= 1'b0;
      end
      if (cmd.keep) begin
        scan_i <= scan_i + 1'b1;
        keep_i <= keep_i + 1'b1;
      end
      if (cmd.wake) begin
        scan_i <= scan_i + 1'b1;
        woke   <= 1'b1;
      end
      if (cmd.finish) begin
        count <= keep_i;
        if (resched_now) begin
          last_resched_ms <= elapsed_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sleep && !full) begin
      ent_pid[count[swtq_pkg::IDX_W-1:0]]  <= pid_q;
      ent_wake[count[swtq_pkg::IDX_W-1:0]] <= elapsed_ms +
          {{(swtq_pkg::TIME_W-swtq_pkg::MSECS_W){1'b0}}, msecs_q};
    end
    if (cmd.keep) begin
      ent_pid[keep_i[swtq_pkg::IDX_W-1:0]]  <= rd_pid;
      ent_wake[keep_i[swtq_pkg::IDX_W-1:0]] <= rd_wake;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sleep || cmd.wake || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sleep) begin
      out_kind       <= full ? swtq_pkg::KIND_REJECT : swtq_pkg::KIND_ACCEPT;
      out_proc_id    <= pid_q;
      out_reschedule <= 1'b0;
      out_last       <= 1'b1;
    end else if (cmd.wake) begin
      out_kind       <= swtq_pkg::KIND_WOKEN;
      out_proc_id    <= rd_pid;
      out_reschedule <= 1'b0;
      out_last       <= 1'b0;
    end else if (cmd.finish) begin
      out_kind       <= swtq_pkg::KIND_TICK;
      out_proc_id    <= '0;
      out_reschedule <= resched_now;
      out_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sleep_wakeup_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sleep_wakeup_timer_queue
// Sleep table with absolute wake times, a millisecond clock and a tick that
// wakes due processes and reports whether to reschedule.
// ----------------------------------------------------------------------------
// A request is taken whenever the block is idle, and the result register lets a
// request be taken while the previous result still waits. A sleep request is
// loaded, then entered once the result register is free. A tick adds to the
// clock, then scans and compacts the table in insertion order one entry per
// cycle while each woken result finds the result register free, over at most a
// full table of 16, then gives the tick-done result. Each woken result and the
// tick-done result wait for the result register to be free, so a stalled result channel holds the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_wakeup_timer_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [swtq_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [swtq_pkg::CFG_W-1:0]   cfg_data,
  swtq_in_if.sink                           item_in,
  swtq_out_if.source                        item_out
);

  swtq_pkg::cmd_t    cmd;
  swtq_pkg::status_t status;

  swtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swtq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (item_in.func),
    .in_pid         (item_in.pid),
    .in_msecs       (item_in.msecs),
    .out_ready      (item_out.ready),
    .out_valid      (item_out.valid),
    .out_kind       (item_out.kind),
    .out_proc_id    (item_out.proc_id),
    .out_reschedule (item_out.reschedule),
    .out_last       (item_out.last),
    .cmd            (cmd),
    .status         (status)
  );

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("request taken while another is in progress");

  a_wake_due: assert property (@(posedge clk) disable iff (rst)
    cmd.wake |-> (status.due && status.out_free && !status.scan_end))
    else $error("wake issued for an entry that is not due or with no room");

  a_tick_last: assert property (@(posedge clk) disable iff (rst)
    (item_out.valid && item_out.kind == swtq_pkg::KIND_TICK) |-> item_out.last)
    else $error("tick-done result without last");

  a_woken_not_last: assert property (@(posedge clk) disable iff (rst)
    (item_out.valid && item_out.kind == swtq_pkg::KIND_WOKEN) |->
      (!item_out.last && !item_out.reschedule))
    else $error("woken result marked last or reschedule");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sleep wake-up timer queue. A short table of
// sleep requests and ticks covers reset values, the full table and the
// extreme field values. Random traffic then runs under a series of register
// settings. Every result is checked against an in-bench model of the sleep
// table and the millisecond clock, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    swtq_pkg::kind_t                kind;
    logic [swtq_pkg::PID_W-1:0]     proc_id;
    logic                           reschedule;
    logic                           last;
  } reply_t;

  typedef struct packed {
    logic                           func;
    logic [swtq_pkg::PID_W-1:0]     pid;
    logic [swtq_pkg::MSECS_W-1:0]   msecs;
    logic                           typed;
    reply_t                         want;
  } plan_row_t;

  localparam int PLAN_LEN   = 23;
  localparam int PHASES     = 6;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_LEN   = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [swtq_pkg::CFGI_W-1:0] cfg_index;
  logic [swtq_pkg::CFG_W-1:0]  cfg_data;

  swtq_in_if  req_ch ();
  swtq_out_if res_ch ();

  sleep_wakeup_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item_in  (req_ch),
    .item_out (res_ch)
  );

  // model of the sleep table
  logic [swtq_pkg::MSPT_W-1:0]  tick_ms;
  logic [swtq_pkg::TSL_W-1:0]   slice_ms;
  logic [swtq_pkg::TIME_W-1:0]  clock_ms;
  logic [swtq_pkg::TIME_W-1:0]  resched_at_ms;
  logic [swtq_pkg::PID_W-1:0]   sleeper_pid [swtq_pkg::ENTRIES];
  logic [swtq_pkg::TIME_W-1:0]  sleeper_due [swtq_pkg::ENTRIES];
  int                           sleeper_cnt;

  reply_t awaited_replies [$];

  bit calm;
  int errors;
  int requests_sent;
  int ticks_sent;
  int replies_seen;
  int wakeups_seen;
  int rejects_seen;
  int settings_used;

  plan_row_t plan [PLAN_LEN] = '{
    '{swtq_pkg::FUNC_TICK,  16'h0000, 32'd0,        1'b1,
      '{swtq_pkg::KIND_TICK,   16'h0000, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h0000, 32'd0,        1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h0000, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'hFFFF, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_TICK,  16'hFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{swtq_pkg::FUNC_SLEEP, 16'h1231, 32'd10,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1231, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1232, 32'd20,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1232, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1233, 32'd30,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1233, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1234, 32'd40,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1234, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1235, 32'd50,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1235, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1236, 32'd60,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1236, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1237, 32'd70,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1237, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1238, 32'd80,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1238, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h1239, 32'd90,  1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h1239, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123A, 32'd100, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123A, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123B, 32'd110, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123B, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123C, 32'd120, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123C, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123D, 32'd130, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123D, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123E, 32'd140, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123E, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h123F, 32'd150, 1'b1,
      '{swtq_pkg::KIND_ACCEPT, 16'h123F, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_SLEEP, 16'h8001, 32'd0,   1'b1,
      '{swtq_pkg::KIND_REJECT, 16'h8001, 1'b0, 1'b1}},
    '{swtq_pkg::FUNC_TICK,  16'h0000, 32'd0,   1'b0, '0},
    '{swtq_pkg::FUNC_TICK,  16'h0000, 32'd0,   1'b0, '0},
    '{swtq_pkg::FUNC_TICK,  16'h0000, 32'd0,   1'b0, '0}
  };

  int unsigned phase_tick_ms  [PHASES] = '{0, 1, 1023, 1000, 37, 5};
  int unsigned phase_slice_ms [PHASES] = '{0, 1, 65535, 50, 200, 0};
  int          phase_len      [PHASES] = '{30, 60, 60, 80, 80, 90};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_queue_model();
    tick_ms       = swtq_pkg::MS_PER_TICK_RST;
    slice_ms      = swtq_pkg::TIMESLICE_RST;
    clock_ms      = '0;
    resched_at_ms = '0;
    sleeper_cnt   = 0;
  endfunction

  function automatic void predict_replies(input logic f,
                                          input logic [swtq_pkg::PID_W-1:0] p,
                                          input logic [swtq_pkg::MSECS_W-1:0] m);
    int   keep;
    logic woke;
    logic resched;
    keep = 0;
    woke = 1'b0;
    if (f == swtq_pkg::FUNC_SLEEP) begin
      if (sleeper_cnt < swtq_pkg::ENTRIES) begin
        sleeper_pid[sleeper_cnt] = p;
        sleeper_due[sleeper_cnt] = clock_ms + swtq_pkg::TIME_W'(m);
        sleeper_cnt++;
        awaited_replies.push_back('{swtq_pkg::KIND_ACCEPT, p, 1'b0, 1'b1});
      end else begin
        awaited_replies.push_back('{swtq_pkg::KIND_REJECT, p, 1'b0, 1'b1});
      end
      return;
    end
    clock_ms = clock_ms + swtq_pkg::TIME_W'(tick_ms);
    for (int i = 0; i < sleeper_cnt; i++) begin
      if (sleeper_due[i] <= clock_ms) begin
        woke = 1'b1;
        awaited_replies.push_back('{swtq_pkg::KIND_WOKEN, sleeper_pid[i], 1'b0, 1'b0});
      end else begin
        sleeper_pid[keep] = sleeper_pid[i];
        sleeper_due[keep] = sleeper_due[i];
        keep++;
      end
    end
    sleeper_cnt = keep;
    resched = woke || ((clock_ms - resched_at_ms) >= swtq_pkg::TIME_W'(slice_ms));
    if (resched) resched_at_ms = clock_ms;
    awaited_replies.push_back('{swtq_pkg::KIND_TICK, '0, resched, 1'b1});
  endfunction

  task automatic put_request(input logic f, input logic [swtq_pkg::PID_W-1:0] p,
                             input logic [swtq_pkg::MSECS_W-1:0] m);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if (!calm && $urandom_range(0, 99) < 27) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.pid   <= p;
        req_ch.msecs <= m;
        @(posedge clk);
        taken = req_ch.ready;
      end
    end
    requests_sent++;
    if (f == swtq_pkg::FUNC_TICK) ticks_sent++;
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [swtq_pkg::MSPT_W-1:0] mspt,
                            input logic [swtq_pkg::TSL_W-1:0] slice);
    cfg_we    <= 1'b1;
    cfg_index <= swtq_pkg::REG_MS_PER_TICK;
    cfg_data  <= swtq_pkg::CFG_W'(mspt);
    @(posedge clk);
    cfg_index <= swtq_pkg::REG_TIMESLICE_MS;
    cfg_data  <= slice;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_ms  = mspt;
    slice_ms = slice;
    settings_used++;
  endtask

  // result channel: random back-pressure plus one long hold-off
  initial begin : reply_sink
    bit held;
    held = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && replies_seen >= HOLD_AFTER) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      replies_seen++;
      if (res_ch.kind == swtq_pkg::KIND_WOKEN) wakeups_seen++;
      if (res_ch.kind == swtq_pkg::KIND_REJECT) rejects_seen++;
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: kind %0d proc_id %h", res_ch.kind, res_ch.proc_id);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        if (res_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
          errors++;
        end
        if (res_ch.proc_id !== want.proc_id) begin
          $error("proc_id: expected %h, got %h", want.proc_id, res_ch.proc_id);
          errors++;
        end
        if (res_ch.reschedule !== want.reschedule) begin
          $error("reschedule: expected %0b, got %0b", want.reschedule, res_ch.reschedule);
          errors++;
        end
        if (res_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_ch.last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic                         f;
    logic [swtq_pkg::PID_W-1:0]   p;
    logic [swtq_pkg::MSECS_W-1:0] m;
    int                           rnd_idx;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.func  = swtq_pkg::FUNC_SLEEP;
    req_ch.pid   = '0;
    req_ch.msecs = '0;
    calm         = 1'b0;
    rnd_idx      = 0;
    reset_queue_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_LEN; r++) begin
      put_request(plan[r].func, plan[r].pid, plan[r].msecs);
      predict_replies(plan[r].func, plan[r].pid, plan[r].msecs);
      if (plan[r].typed) awaited_replies[awaited_replies.size() - 1] = plan[r].want;
    end
    drain_replies();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(swtq_pkg::MSPT_W'(phase_tick_ms[ph]), swtq_pkg::TSL_W'(phase_slice_ms[ph]));
      for (int n = 0; n < phase_len[ph]; n++) begin
        calm = (rnd_idx >= 150 && rnd_idx < 230);
        if (rnd_idx == 300) drain_replies();
        f = ($urandom_range(0, 99) < 35) ? swtq_pkg::FUNC_TICK : swtq_pkg::FUNC_SLEEP;
        p = swtq_pkg::PID_W'($urandom);
        if ($urandom_range(0, 99) < 5) m = $urandom_range(0, 131071);
        else m = $urandom_range(0, 6 * tick_ms + 3);
        put_request(f, p, m);
        predict_replies(f, p, m);
        rnd_idx++;
      end
      drain_replies();
    end

    calm = 1'b0;
    for (int c = 0; c < 20000 && awaited_replies.size() != 0; c++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      $error("%0d expected results never arrived", awaited_replies.size());
      errors++;
    end
    $display("Sent %0d requests (%0d ticks) over %0d register settings plus reset values.",
             requests_sent, ticks_sent, settings_used);
    $display("Checked %0d results: %0d wake-ups, %0d rejects, %0d mismatches.",
             replies_seen, wakeups_seen, rejects_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/swtq_pkg.sv
sv/swtq_in_if.sv
sv/swtq_out_if.sv
sv/swtq_ctrl.sv
sv/swtq_dp.sv
sv/sleep_wakeup_timer_queue.sv
tb/sv/tb_top.sv
